FILE: rtl/stbe_pkg.sv
// Shared types, opcodes and constants for the sequence track byte encoder.
// Used by stbe_build, stbe_serial, sequence_track_byte_encoder_core and the testbench.
`timescale 1ns / 1ps

package stbe_pkg;

   localparam int TIME_BITS   = 28;
   localparam int MAX_RESULTS = 11;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   localparam logic [5:0] OP_START      = 6'd0;
   localparam logic [5:0] OP_END        = 6'd1;
   localparam logic [5:0] OP_NOTE       = 6'd2;
   localparam logic [5:0] OP_VOLUME     = 6'd3;
   localparam logic [5:0] OP_PAN        = 6'd4;
   localparam logic [5:0] OP_EXPR       = 6'd5;
   localparam logic [5:0] OP_BEND       = 6'd6;
   localparam logic [5:0] OP_BEND_RANGE = 6'd7;
   localparam logic [5:0] OP_PATCH      = 6'd8;
   localparam logic [5:0] OP_LOOP_START = 6'd9;
   localparam logic [5:0] OP_LOOP_END   = 6'd10;
   localparam logic [5:0] OP_TEMPO      = 6'd11;
   localparam logic [5:0] OP_TRANSPOSE  = 6'd12;
   localparam logic [5:0] OP_MOD_DEPTH  = 6'd13;
   localparam logic [5:0] OP_PORTA_TIME = 6'd14;
   localparam logic [5:0] OP_PRIORITY   = 6'd15;
   localparam logic [5:0] OP_MOD_SPEED  = 6'd16;
   localparam logic [5:0] OP_MOD_TYPE   = 6'd17;
   localparam logic [5:0] OP_MOD_RANGE  = 6'd18;
   localparam logic [5:0] OP_MOD_DELAY  = 6'd19;
   localparam logic [5:0] OP_NOTEWAIT   = 6'd20;
   localparam logic [5:0] OP_PORTA_CTRL = 6'd21;
   localparam logic [5:0] OP_PORTA_SW   = 6'd22;
   localparam logic [5:0] OP_ATTACK     = 6'd23;
   localparam logic [5:0] OP_DECAY      = 6'd24;
   localparam logic [5:0] OP_SUSTAIN    = 6'd25;
   localparam logic [5:0] OP_RELEASE    = 6'd26;
   localparam logic [5:0] OP_SWEEP      = 6'd27;
   localparam logic [5:0] OP_RANDOM     = 6'd28;
   localparam logic [5:0] OP_USE_VAR    = 6'd29;
   localparam logic [5:0] OP_IF         = 6'd30;
   localparam logic [5:0] OP_VAR_OP     = 6'd31;
   localparam logic [5:0] OP_TIE        = 6'd32;
   localparam logic [5:0] OP_PRINT_VAR  = 6'd33;
   localparam logic [5:0] OP_MASTER_VOL = 6'd34;
   localparam logic [5:0] OP_REST_ONLY  = 6'd35;

   localparam logic [15:0] TEMPO_MAX   = 16'd240;
   localparam logic [7:0]  VAR_OP_SKIP = 8'd7;
   localparam logic [7:0]  VAR_OP_LAST = 8'd13;

   typedef struct packed {
      logic [5:0]           opcode;
      logic [TIME_BITS-1:0] event_time;
      logic [TIME_BITS-1:0] note_length;
      logic [7:0]           param_a;
      logic [7:0]           param_b;
      logic [15:0]          wide_a;
      logic [15:0]          wide_b;
      logic [31:0]          track_offset;
   } item_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [COUNT_W-1:0]          count;
      logic                        order_error;
   } frame_type;

endpackage

FILE: rtl/stbe_build.sv
// Builds the byte frame of one request and holds the track state
// (time, loop and byte positions, order error). Depends on stbe_pkg.
`timescale 1ns / 1ps

module stbe_build import stbe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  item_type  item,
   input  logic      commit,
   output frame_type frame
);

   localparam logic [7:0] REST_BYTE    = 8'h80;
   localparam logic [7:0] TRACK_BYTE   = 8'hC7;
   localparam logic [7:0] END_BYTE     = 8'hFF;
   localparam logic [7:0] JUMP_BYTE    = 8'h94;
   localparam logic [7:0] VAR_OP_BASE  = 8'hB0;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } varlen_type;

   // Big-endian 7-bit groups, continuation bit on all but the last byte.
   function automatic varlen_type varlen(input logic [TIME_BITS-1:0] v);
      varlen_type r;
      logic [27:0] x;
      x = 28'(v);
      r.bytes = '0;
      if (x[27:21] != 7'd0) begin
         r.len = 3'd4;
         r.bytes[0] = {1'b1, x[27:21]};
         r.bytes[1] = {1'b1, x[20:14]};
         r.bytes[2] = {1'b1, x[13:7]};
         r.bytes[3] = {1'b0, x[6:0]};
      end else if (x[20:14] != 7'd0) begin
         r.len = 3'd3;
         r.bytes[0] = {1'b1, x[20:14]};
         r.bytes[1] = {1'b1, x[13:7]};
         r.bytes[2] = {1'b0, x[6:0]};
      end else if (x[13:7] != 7'd0) begin
         r.len = 3'd2;
         r.bytes[0] = {1'b1, x[13:7]};
         r.bytes[1] = {1'b0, x[6:0]};
      end else begin
         r.len = 3'd1;
         r.bytes[0] = {1'b0, x[6:0]};
      end
      return r;
   endfunction

   logic [TIME_BITS-1:0] prev_time_ff, prev_time_in;
   logic [31:0]          loop_pos_ff, loop_pos_in;
   logic [31:0]          byte_pos_ff, byte_pos_in;
   logic                 failed_ff, failed_in;

   logic [TIME_BITS-1:0] delta;
   varlen_type           delta_vl;
   varlen_type           length_vl;
   logic [7:0][7:0]      rest;
   logic [2:0]           rest_cnt;
   logic [7:0][7:0]      cmd;
   logic [2:0]           cmd_cnt;
   logic                 loop_mark;
   logic                 backward;
   logic [7:0]           a_low;
   logic [3:0]           k_idx;
   logic [3:0]           c_idx;
   logic [COUNT_W-1:0]   total;

   assign delta     = item.event_time - prev_time_ff;
   assign delta_vl  = varlen(delta);
   assign length_vl = varlen(item.note_length);
   assign backward  = item.event_time < prev_time_ff;
   assign a_low     = {1'b0, item.param_a[6:0]};

   // Rest prefix: 0x80 plus the delta, only when time advances.
   always_comb begin
      rest = '0;
      rest_cnt = 3'd0;
      if (delta != '0) begin
         rest[0] = REST_BYTE;
         rest[1] = delta_vl.bytes[0];
         rest[2] = delta_vl.bytes[1];
         rest[3] = delta_vl.bytes[2];
         rest[4] = delta_vl.bytes[3];
         rest_cnt = 3'd1 + delta_vl.len;
      end
   end

   // Command bytes of timed opcodes.
   always_comb begin
      cmd = '0;
      cmd_cnt = 3'd0;
      loop_mark = 1'b0;
      unique case (item.opcode)
         OP_NOTE: begin
            if (item.note_length != '0) begin
               cmd[0] = a_low;
               cmd[1] = {1'b0, item.param_b[6:0]};
               cmd[2] = length_vl.bytes[0];
               cmd[3] = length_vl.bytes[1];
               cmd[4] = length_vl.bytes[2];
               cmd[5] = length_vl.bytes[3];
               cmd_cnt = 3'd2 + length_vl.len;
            end
         end
         OP_VOLUME:     begin cmd[0] = 8'hC1; cmd[1] = a_low; cmd_cnt = 3'd2; end
         OP_PAN:        begin cmd[0] = 8'hC0; cmd[1] = a_low; cmd_cnt = 3'd2; end
         OP_EXPR:       begin cmd[0] = 8'hD5; cmd[1] = a_low; cmd_cnt = 3'd2; end
         OP_BEND_RANGE: begin cmd[0] = 8'hC5; cmd[1] = a_low; cmd_cnt = 3'd2; end
         OP_PATCH:      begin cmd[0] = 8'h81; cmd[1] = a_low; cmd_cnt = 3'd2; end
         OP_LOOP_START: loop_mark = 1'b1;
         OP_LOOP_END: begin
            cmd[0] = JUMP_BYTE;
            cmd[1] = loop_pos_ff[7:0];
            cmd[2] = loop_pos_ff[15:8];
            cmd[3] = loop_pos_ff[23:16];
            cmd[4] = loop_pos_ff[31:24];
            cmd_cnt = 3'd5;
         end
         OP_TEMPO: begin
            if (item.wide_a <= TEMPO_MAX) begin
               cmd[0] = 8'hE1;
               cmd[1] = item.wide_a[7:0];
               cmd[2] = item.wide_a[15:8];
               cmd_cnt = 3'd3;
            end
         end
         OP_MOD_DELAY: begin
            cmd[0] = 8'hE0;
            cmd[1] = item.param_a;
            cmd[2] = 8'h00;
            cmd_cnt = 3'd3;
         end
         OP_SWEEP: begin
            cmd[0] = 8'hE3;
            cmd[1] = item.wide_a[7:0];
            cmd[2] = item.wide_a[15:8];
            cmd_cnt = 3'd3;
         end
         OP_RANDOM: begin
            cmd[0] = 8'hA0;
            cmd[1] = item.param_a;
            cmd[2] = item.wide_a[7:0];
            cmd[3] = item.wide_a[15:8];
            cmd[4] = item.wide_b[7:0];
            cmd[5] = item.wide_b[15:8];
            cmd_cnt = 3'd6;
         end
         OP_USE_VAR: begin
            cmd[0] = 8'hA1;
            cmd[1] = item.param_a;
            cmd[2] = item.param_b;
            cmd_cnt = 3'd3;
         end
         OP_VAR_OP: begin
            if (item.param_b <= VAR_OP_LAST && item.param_b != VAR_OP_SKIP) begin
               cmd[0] = VAR_OP_BASE + item.param_b;
               cmd[1] = item.param_a;
               cmd[2] = item.wide_a[7:0];
               cmd[3] = item.wide_a[15:8];
               cmd_cnt = 3'd4;
            end
         end
         OP_BEND:       begin cmd[0] = 8'hC4; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_TRANSPOSE:  begin cmd[0] = 8'hC3; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_MOD_DEPTH:  begin cmd[0] = 8'hCA; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_PORTA_TIME: begin cmd[0] = 8'hCF; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_PRIORITY:   begin cmd[0] = 8'hC6; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_MOD_SPEED:  begin cmd[0] = 8'hCB; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_MOD_TYPE:   begin cmd[0] = 8'hCC; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_MOD_RANGE:  begin cmd[0] = 8'hCD; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_NOTEWAIT:   begin cmd[0] = 8'hC7; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_PORTA_CTRL: begin cmd[0] = 8'hC9; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_PORTA_SW:   begin cmd[0] = 8'hCE; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_ATTACK:     begin cmd[0] = 8'hD0; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_DECAY:      begin cmd[0] = 8'hD1; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_SUSTAIN:    begin cmd[0] = 8'hD2; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_RELEASE:    begin cmd[0] = 8'hD3; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_IF:         begin cmd[0] = 8'hA2; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_TIE:        begin cmd[0] = 8'hC8; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_PRINT_VAR:  begin cmd[0] = 8'hD6; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         OP_MASTER_VOL: begin cmd[0] = 8'hC2; cmd[1] = item.param_a; cmd_cnt = 3'd2; end
         default: begin
            cmd = '0;
            cmd_cnt = 3'd0;
         end
      endcase
   end

   // Assemble the frame and the next track state.
   always_comb begin
      frame = '0;
      prev_time_in = prev_time_ff;
      loop_pos_in = loop_pos_ff;
      failed_in = failed_ff;
      total = '0;
      k_idx = '0;
      c_idx = '0;
      if (item.opcode == OP_START) begin
         frame.bytes[0] = TRACK_BYTE;
         frame.bytes[1] = 8'h00;
         total = COUNT_W'(2);
         prev_time_in = '0;
         failed_in = 1'b0;
         loop_pos_in = item.track_offset + 32'd2;
      end else if (item.opcode == OP_END) begin
         frame.bytes[0] = END_BYTE;
         total = COUNT_W'(1);
      end else if (backward) begin
         failed_in = 1'b1;
      end else begin
         prev_time_in = item.event_time;
         total = COUNT_W'(rest_cnt) + COUNT_W'(cmd_cnt);
         if (loop_mark) begin
            loop_pos_in = byte_pos_ff + 32'(rest_cnt);
         end
         for (int k = 0; k < MAX_RESULTS; k++) begin
            k_idx = 4'(k);
            c_idx = k_idx - {1'b0, rest_cnt};
            if (k_idx < {1'b0, rest_cnt}) begin
               frame.bytes[k] = rest[k_idx[2:0]];
            end else if (c_idx < {1'b0, cmd_cnt}) begin
               frame.bytes[k] = cmd[c_idx[2:0]];
            end
         end
      end
      frame.count = total;
      frame.order_error = failed_in;
      if (item.opcode == OP_START) begin
         byte_pos_in = item.track_offset + 32'd2;
      end else begin
         byte_pos_in = byte_pos_ff + 32'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         loop_pos_ff  <= '0;
         byte_pos_ff  <= '0;
         failed_ff    <= 1'b0;
      end else if (commit) begin
         prev_time_ff <= prev_time_in;
         loop_pos_ff  <= loop_pos_in;
         byte_pos_ff  <= byte_pos_in;
         failed_ff    <= failed_in;
      end
   end

endmodule

FILE: rtl/stbe_serial.sv
// Byte serializer: loads one frame and shifts it out a byte per cycle while rsp_stall is low.
// Depends on stbe_pkg.
`timescale 1ns / 1ps

module stbe_serial import stbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  frame_type  frame,
   input  logic       load,
   output logic       load_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_order_error
);

   logic [COUNT_W-1:0]          cnt_ff, cnt_in;
   logic [MAX_RESULTS-1:0][7:0] buf_ff, buf_in;
   logic                        err_ff, err_in;
   logic                        take;

   assign rsp_valid       = cnt_ff != '0;
   assign take            = rsp_valid && !rsp_stall;
   assign rsp_out_byte    = buf_ff[0];
   assign rsp_run_last    = cnt_ff == COUNT_W'(1);
   assign rsp_order_error = err_ff;
   // Free when empty, or when the last byte leaves this cycle.
   assign load_ready      = !rsp_valid || (rsp_run_last && !rsp_stall);

   always_comb begin
      cnt_in = cnt_ff;
      buf_in = buf_ff;
      err_in = err_ff;
      if (load) begin
         cnt_in = frame.count;
         buf_in = frame.bytes;
         err_in = frame.order_error;
      end else if (take) begin
         cnt_in = cnt_ff - COUNT_W'(1);
         buf_in = {8'h00, buf_ff[MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      err_ff <= err_in;
   end

endmodule

FILE: rtl/sequence_track_byte_encoder_core.sv
// Sequence track byte encoder. An accepted request is held in the request register
// until the byte serializer is free, then built and loaded into the serializer.
// Throughput: one byte per cycle while rsp_stall is low, set by the single output byte
// lane. A request emits 0 to 11 bytes; the next one can wait in the request register.
// Synchronous reset clears all track state, the held flag and the serializer count.
// Depends on stbe_pkg, stbe_build and stbe_serial.
`timescale 1ns / 1ps

module sequence_track_byte_encoder_core import stbe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [5:0]           req_opcode,
   input  logic [TIME_BITS-1:0] req_event_time,
   input  logic [TIME_BITS-1:0] req_note_length,
   input  logic [7:0]           req_param_a,
   input  logic [7:0]           req_param_b,
   input  logic [15:0]          req_wide_a,
   input  logic [15:0]          req_wide_b,
   input  logic [31:0]          req_track_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_order_error
);

   item_type  item_ff;
   logic      held_ff, held_in;
   logic      accept;
   logic      advance;
   logic      ser_ready;
   frame_type frame;

   assign advance   = held_ff && ser_ready;
   assign req_stall = held_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         held_in = 1'b1;
      end else if (advance) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{opcode:       req_opcode,
                      event_time:   req_event_time,
                      note_length:  req_note_length,
                      param_a:      req_param_a,
                      param_b:      req_param_b,
                      wide_a:       req_wide_a,
                      wide_b:       req_wide_b,
                      track_offset: req_track_offset};
      end
   end

   stbe_build u_build (
      .clock  (clock),
      .reset  (reset),
      .item   (item_ff),
      .commit (advance),
      .frame  (frame)
   );

   stbe_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .frame           (frame),
      .load            (advance),
      .load_ready      (ser_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_order_error (rsp_order_error)
   );

endmodule

FILE: test/tb_top.sv
// Testbench for sequence_track_byte_encoder_core: a scoreboard class predicts the
// byte stream of each request, plain tasks drive requests under bursts and stalls.
// Depends on stbe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_top import stbe_pkg::*; ();

   localparam logic [5:0]  OP_UNDEFINED_TOP = 6'd63;
   localparam int          RANDOM_REQUESTS  = 500;

   class track_byte_scoreboard;
      typedef struct packed {
         logic [7:0] data;
         logic       last;
         logic       error;
      } track_byte_type;

      track_byte_type       pending[$];
      logic [7:0]           frame[$];
      logic [TIME_BITS-1:0] last_time;
      logic [31:0]          loop_pos;
      logic [31:0]          byte_pos;
      logic                 failed;
      int                   errors;

      function new();
         last_time = '0;
         loop_pos  = '0;
         byte_pos  = '0;
         failed    = 1'b0;
         errors    = 0;
      endfunction

      // drop bytes past the per-request limit
      function void put_byte(logic [7:0] data);
         if (frame.size() < MAX_RESULTS) begin
            frame.insert(frame.size(), data);
            byte_pos = byte_pos + 32'd1;
         end
      endfunction

      function void put16(logic [15:0] word);
         put_byte(word[7:0]);
         put_byte(word[15:8]);
      endfunction

      // big-endian 7-bit groups, continuation bit on all but the last
      function void put_varlen(logic [31:0] value);
         int         groups;
         int         i;
         logic [7:0] group;
         groups = 1;
         while (groups < 5 && (value >> (7 * groups)) != 0)
            groups++;
         for (i = groups - 1; i >= 0; i--) begin
            group = 8'((value >> (7 * i)) & 32'h7F);
            if (i != 0)
               group[7] = 1'b1;
            put_byte(group);
         end
      endfunction

      function void note_request(item_type req);
         logic [TIME_BITS-1:0] delta;
         logic [7:0]           a;
         logic [7:0]           b;
         track_byte_type       entry;
         a = req.param_a;
         b = req.param_b;
         frame.delete();
         if (req.opcode == OP_START) begin
            last_time = '0;
            failed    = 1'b0;
            byte_pos  = req.track_offset;
            put_byte(8'hC7);
            put_byte(8'h00);
            loop_pos  = byte_pos;
         end else if (req.opcode == OP_END) begin
            put_byte(8'hFF);
         end else if (req.event_time < last_time) begin
            failed = 1'b1;
         end else begin
            delta = req.event_time - last_time;
            if (delta != 0) begin
               put_byte(8'h80);
               put_varlen(32'(delta));
            end
            last_time = req.event_time;
            case (req.opcode)
               OP_NOTE: if (req.note_length != 0) begin
                  put_byte({1'b0, a[6:0]});
                  put_byte({1'b0, b[6:0]});
                  put_varlen(32'(req.note_length));
               end
               OP_VOLUME:       begin put_byte(8'hC1); put_byte({1'b0, a[6:0]}); end
               OP_PAN:          begin put_byte(8'hC0); put_byte({1'b0, a[6:0]}); end
               OP_EXPR:         begin put_byte(8'hD5); put_byte({1'b0, a[6:0]}); end
               OP_BEND:         begin put_byte(8'hC4); put_byte(a); end
               OP_BEND_RANGE:   begin put_byte(8'hC5); put_byte({1'b0, a[6:0]}); end
               OP_PATCH:        begin put_byte(8'h81); put_byte({1'b0, a[6:0]}); end
               OP_LOOP_START:   loop_pos = byte_pos;
               OP_LOOP_END: begin
                  put_byte(8'h94);
                  put16(loop_pos[15:0]);
                  put16(loop_pos[31:16]);
               end
               OP_TEMPO: if (req.wide_a <= TEMPO_MAX) begin
                  put_byte(8'hE1);
                  put16(req.wide_a);
               end
               OP_TRANSPOSE:    begin put_byte(8'hC3); put_byte(a); end
               OP_MOD_DEPTH:    begin put_byte(8'hCA); put_byte(a); end
               OP_PORTA_TIME:   begin put_byte(8'hCF); put_byte(a); end
               OP_PRIORITY:     begin put_byte(8'hC6); put_byte(a); end
               OP_MOD_SPEED:    begin put_byte(8'hCB); put_byte(a); end
               OP_MOD_TYPE:     begin put_byte(8'hCC); put_byte(a); end
               OP_MOD_RANGE:    begin put_byte(8'hCD); put_byte(a); end
               OP_MOD_DELAY:    begin put_byte(8'hE0); put16({8'h00, a}); end
               OP_NOTEWAIT:     begin put_byte(8'hC7); put_byte(a); end
               OP_PORTA_CTRL:   begin put_byte(8'hC9); put_byte(a); end
               OP_PORTA_SW:     begin put_byte(8'hCE); put_byte(a); end
               OP_ATTACK:       begin put_byte(8'hD0); put_byte(a); end
               OP_DECAY:        begin put_byte(8'hD1); put_byte(a); end
               OP_SUSTAIN:      begin put_byte(8'hD2); put_byte(a); end
               OP_RELEASE:      begin put_byte(8'hD3); put_byte(a); end
               OP_SWEEP:        begin put_byte(8'hE3); put16(req.wide_a); end
               OP_RANDOM: begin
                  put_byte(8'hA0);
                  put_byte(a);
                  put16(req.wide_a);
                  put16(req.wide_b);
               end
               OP_USE_VAR:      begin put_byte(8'hA1); put_byte(a); put_byte(b); end
               OP_IF:           begin put_byte(8'hA2); put_byte(a); end
               OP_VAR_OP: if (b <= VAR_OP_LAST && b != VAR_OP_SKIP) begin
                  put_byte(8'hB0 + b);
                  put_byte(a);
                  put16(req.wide_a);
               end
               OP_TIE:          begin put_byte(8'hC8); put_byte(a); end
               OP_PRINT_VAR:    begin put_byte(8'hD6); put_byte(a); end
               OP_MASTER_VOL:   begin put_byte(8'hC2); put_byte(a); end
               default: ;
            endcase
         end
         foreach (frame[k]) begin
            entry = '{data: frame[k], last: (k == frame.size() - 1), error: failed};
            pending.insert(pending.size(), entry);
         end
      endfunction

      function void check_result(logic [7:0] data, logic last, logic error);
         track_byte_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual byte %h last %b error %b",
                     $time, data, last, error);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.last, last);
            errors++;
         end
         if (error !== want.error) begin
            $display("%0t: order_error expected %b actual %b", $time, want.error, error);
            errors++;
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [5:0]           req_opcode       = '0;
   logic [TIME_BITS-1:0] req_event_time   = '0;
   logic [TIME_BITS-1:0] req_note_length  = '0;
   logic [7:0]           req_param_a      = '0;
   logic [7:0]           req_param_b      = '0;
   logic [15:0]          req_wide_a       = '0;
   logic [15:0]          req_wide_b       = '0;
   logic [31:0]          req_track_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_run_last;
   logic                 rsp_order_error;

   track_byte_scoreboard board = new();
   int                   burst_left = 0;
   int                   stall_mode = 0;
   int                   stall_left = 0;
   int                   stall_tick = 0;

   sequence_track_byte_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_event_time   (req_event_time),
      .req_note_length  (req_note_length),
      .req_param_a      (req_param_a),
      .req_param_b      (req_param_b),
      .req_wide_a       (req_wide_a),
      .req_wide_b       (req_wide_b),
      .req_track_offset (req_track_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_order_error  (rsp_order_error)
   );

   always #5 clock = ~clock;

   function automatic item_type make_item(logic [5:0] op, logic [31:0] stamp,
                                          logic [31:0] length, logic [7:0] a, logic [7:0] b,
                                          logic [15:0] wa, logic [15:0] wb,
                                          logic [31:0] offset);
      item_type req;
      req.opcode       = op;
      req.event_time   = stamp[TIME_BITS-1:0];
      req.note_length  = length[TIME_BITS-1:0];
      req.param_a      = a;
      req.param_b      = b;
      req.wide_a       = wa;
      req.wide_b       = wb;
      req.track_offset = offset;
      return req;
   endfunction

   // mostly short tick counts, now and then up to the full time width
   function automatic logic [31:0] rand_ticks();
      case ($urandom_range(0, 7))
         0, 1:    return 32'd0;
         2, 3, 4: return $urandom_range(1, 127);
         5:       return $urandom_range(128, 16383);
         6:       return $urandom_range(16384, 2097151);
         default: return $urandom & 32'h0FFF_FFFF;
      endcase
   endfunction

   // Hold the request until a clock edge sees it unstalled; stall is sampled
   // at the falling edge, where all inputs have settled.
   task automatic send_request(item_type req);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid        <= 1'b1;
      req_opcode       <= req.opcode;
      req_event_time   <= req.event_time;
      req_note_length  <= req.note_length;
      req_param_a      <= req.param_a;
      req_param_b      <= req.param_b;
      req_wide_a       <= req.wide_a;
      req_wide_b       <= req.wide_b;
      req_track_offset <= req.track_offset;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end while (!taken);
      board.note_request(req);
      burst_left--;
   endtask

   // receiver: phases of no stall, coin-flip stall, heavy periodic stall, rare stall
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         2:       rsp_stall <= (stall_tick % 4) != 0;
         default: rsp_stall <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_result(rsp_out_byte, rsp_run_last, rsp_order_error);
   end

   initial begin : stimulus
      item_type             req;
      logic [TIME_BITS-1:0] now;
      logic [5:0]           op;
      int                   sent;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // offset at the top so the byte position wraps
      send_request(make_item(OP_START, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFE));
      send_request(make_item(OP_NOTE, 0, 32'h0FFF_FFFF, 8'hFF, 8'hFF, 0, 0, 0));
      // zero length: rest only
      send_request(make_item(OP_NOTE, 32'h7F, 0, 8'h12, 8'h34, 0, 0, 0));
      // longest request: rest with a four-group delta plus random
      send_request(make_item(OP_RANDOM, 32'h0FFF_FFFF, 0, 8'hFF, 8'hFF,
                             16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      // backward step: dropped, flag raised
      send_request(make_item(OP_VOLUME, 32'd5, 0, 8'h40, 0, 0, 0, 0));
      send_request(make_item(OP_PAN, 32'h0FFF_FFFF, 0, 8'hFF, 0, 0, 0, 0));
      send_request(make_item(OP_END, 32'd3, 0, 0, 0, 0, 0, 0));
      send_request(make_item(OP_START, 0, 0, 0, 0, 0, 0, 32'h0000_0010));
      send_request(make_item(OP_LOOP_START, 32'h80, 0, 0, 0, 0, 0, 0));
      send_request(make_item(OP_TEMPO, 32'h80, 0, 0, 0, TEMPO_MAX, 0, 0));
      send_request(make_item(OP_TEMPO, 32'h80, 0, 0, 0, TEMPO_MAX + 16'd1, 0, 0));
      send_request(make_item(OP_VAR_OP, 32'h80, 0, 8'h55, VAR_OP_SKIP, 16'h1234, 0, 0));
      send_request(make_item(OP_VAR_OP, 32'h81, 0, 8'hAA, VAR_OP_LAST, 16'h1234, 0, 0));
      send_request(make_item(OP_VAR_OP, 32'h81, 0, 8'hAA, VAR_OP_LAST + 8'd1, 16'h1, 0, 0));
      send_request(make_item(OP_VAR_OP, 32'h81, 0, 8'h01, 8'd0, 16'hFFFF, 0, 0));
      send_request(make_item(OP_MOD_DELAY, 32'h81, 0, 8'h55, 0, 0, 0, 0));
      send_request(make_item(OP_LOOP_END, 32'h100, 0, 0, 0, 0, 0, 0));
      send_request(make_item(OP_REST_ONLY, 32'h4000, 0, 0, 0, 0, 0, 0));
      send_request(make_item(OP_UNDEFINED_TOP, 32'h4001, 0, 8'hFF, 8'hFF, 0, 0, 0));
      send_request(make_item(OP_BEND, 32'h4001, 0, 8'h80, 0, 0, 0, 0));
      send_request(make_item(OP_USE_VAR, 32'h4001, 0, 8'hFE, 8'hEF, 0, 0, 0));
      send_request(make_item(OP_NOTE, 32'h4002, 32'd1, 8'h00, 8'h00, 0, 0, 0));
      send_request(make_item(OP_END, 0, 0, 0, 0, 0, 0, 0));

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 9) == 0) begin
            // anything the fields allow, outside any track structure
            send_request(make_item(6'($urandom), $urandom, $urandom, 8'($urandom),
                                   8'($urandom), 16'($urandom), 16'($urandom), $urandom));
            sent++;
         end else begin
            now = '0;
            send_request(make_item(OP_START, $urandom, $urandom, 8'($urandom), 8'($urandom),
                                   16'($urandom), 16'($urandom),
                                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4095)));
            sent++;
            repeat ($urandom_range(4, 40)) begin
               case ($urandom_range(0, 19))
                  0:       op = 6'($urandom_range(36, 63));
                  1:       op = OP_LOOP_START;
                  2:       op = OP_LOOP_END;
                  default: op = 6'($urandom_range(OP_NOTE, OP_REST_ONLY));
               endcase
               req = make_item(op, 0, rand_ticks(), 8'($urandom),
                               8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom),
                               16'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom),
                               16'($urandom), 32'($urandom));
               // step back now and then, otherwise advance (may wrap)
               if ($urandom_range(0, 19) == 0)
                  req.event_time = TIME_BITS'($urandom_range(0, now));
               else
                  req.event_time = TIME_BITS'(now + rand_ticks());
               if (req.event_time >= now)
                  now = req.event_time;
               send_request(req);
               sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
               send_request(make_item(OP_END, $urandom, $urandom, 8'($urandom), 8'($urandom),
                                      16'($urandom), 16'($urandom), $urandom));
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
rtl/stbe_pkg.sv
rtl/stbe_build.sv
rtl/stbe_serial.sv
rtl/sequence_track_byte_encoder_core.sv
test/tb_top.sv
